>>> hdl/r256t_pkg.sv
`timescale 1ns / 1ps

package r256t_pkg;

  // Fixed trie geometry: one key byte per level, most significant first
  localparam int KEY_LEVELS = 8;
  localparam int FANOUT     = 256;
  localparam logic [2:0] LEVEL_LAST = 3'(KEY_LEVELS - 1);

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       walk;
    logic       leaf;
    logic       load_out;
    logic [2:0] level;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic step_ok;
    logic is_lookup;
    logic out_free;
  } dp_sts_t;

  // Key byte for a level, level 0 is the most significant byte
  function automatic logic [7:0] key_octet(input logic [63:0] key, input logic [2:0] lvl);
    key_octet = key[{~lvl, 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/radix256_trie_insert_lookup.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_data   (func, key, value)
// out       out_valid / out_ready out_data  (status, read_value)
//
// One operation at a time: an accept, a child-table read per key level for up to eight
// levels (each child-table read feeds the next address), one leaf read for a lookup,
// and a load of the output register. No new operation is taken until that load.
// After reset the child and node tables are swept with in_ready low. A waiting output
// result stalls the following result's load (not its walk), which holds in_ready low.

module radix256_trie_insert_lookup #(
  parameter int NODE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r256t_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r256t_pkg::out_item_t out_data
);

  r256t_pkg::ctrl_cmd_t cmd;
  r256t_pkg::dp_sts_t   sts;

  r256t_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  r256t_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> hdl/r256t_ctrl.sv
`timescale 1ns / 1ps

module r256t_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  r256t_pkg::dp_sts_t  sts,
  output r256t_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_LEAF  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] level_r, level_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  // One operation: walk the levels, read a lookup's leaf, hand off the result
  always_comb begin
    state_nxt    = state_r;
    level_nxt    = level_r;
    cmd          = '0;
    cmd.level    = level_r;
    cmd.accept   = accept;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          level_nxt = 3'd0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.step_ok) begin
          state_nxt = S_RESP;
        end else if (level_r == r256t_pkg::LEVEL_LAST) begin
          state_nxt = sts.is_lookup ? S_LEAF : S_RESP;
        end else begin
          level_nxt = level_r + 3'd1;
        end
      end
      S_LEAF: begin
        cmd.leaf  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      level_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

>>> hdl/r256t_dp.sv
`timescale 1ns / 1ps

module r256t_dp #(
  parameter int NODE_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  r256t_pkg::in_item_t   in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output r256t_pkg::out_item_t  out_data,
  input  r256t_pkg::ctrl_cmd_t  cmd,
  output r256t_pkg::dp_sts_t    sts
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int AW = NW + 8;
  localparam int LINK_DEPTH = NODE_COUNT * r256t_pkg::FANOUT;
  localparam logic [AW-1:0] CLR_LAST = AW'(LINK_DEPTH - 1);
  localparam logic [NW:0]   POOL_END = (NW + 1)'(NODE_COUNT);

  // Child links and per-node leaf mark with value
  logic [NW-1:0] link_mem [LINK_DEPTH];
  logic [64:0]   node_mem [NODE_COUNT];

  logic [NW-1:0] link_rdata_r;
  logic [64:0]   node_rdata_r;
  logic [AW-1:0] clr_cnt_r;
  logic [NW:0]   next_free_r;
  logic [NW-1:0] cur_r;
  logic          func_r;
  logic [63:0]   key_r;
  logic [63:0]   value_r;
  logic [1:0]    res_status_r;
  logic [63:0]   res_value_r;
  logic          out_valid_r;
  r256t_pkg::out_item_t out_data_r;

  logic [7:0]    walk_byte, next_byte;
  logic          hit, pool_full, alloc, step_ok, last, is_insert;
  logic [NW-1:0] nxt_node;
  logic [AW-1:0] link_raddr, link_waddr;
  logic [NW-1:0] link_wdata;
  logic          link_we;
  logic [NW-1:0] node_waddr;
  logic [64:0]   node_wdata;
  logic          node_we;

  // Step decision for the current level
  assign walk_byte = r256t_pkg::key_octet(key_r, cmd.level);
  assign next_byte = r256t_pkg::key_octet(key_r, cmd.level + 3'd1);
  assign is_insert = (func_r == r256t_pkg::FUNC_INSERT);
  assign hit       = |link_rdata_r;
  assign pool_full = (next_free_r == POOL_END);
  assign alloc     = !hit && is_insert && !pool_full;
  assign step_ok   = hit || alloc;
  assign nxt_node  = hit ? link_rdata_r : next_free_r[NW-1:0];
  assign last      = (cmd.level == r256t_pkg::LEVEL_LAST);

  // Link table port selection
  assign link_raddr = cmd.accept ?
                      {NW'(0), r256t_pkg::key_octet(in_data.key, 3'd0)} :
                      {nxt_node, next_byte};
  assign link_we    = cmd.clear | (cmd.walk & alloc);
  assign link_waddr = cmd.clear ? clr_cnt_r : {cur_r, walk_byte};
  assign link_wdata = cmd.clear ? '0 : next_free_r[NW-1:0];

  // Node table port selection
  assign node_we    = cmd.clear | (cmd.walk & step_ok & last & is_insert);
  assign node_waddr = cmd.clear ? clr_cnt_r[AW-1:8] : nxt_node;
  assign node_wdata = cmd.clear ? '0 : {1'b1, value_r};

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata_r <= node_mem[nxt_node];
  end

  // Clear sweep counter and node allocator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      next_free_r <= (NW + 1)'(1);
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.walk && alloc) next_free_r <= next_free_r + (NW + 1)'(1);
    end
  end

  // Operation registers and walk cursor
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_data.func;
      key_r   <= in_data.key;
      value_r <= in_data.value;
      cur_r   <= '0;
    end else if (cmd.walk) begin
      cur_r <= nxt_node;
    end
  end

  // Capture the result on each walk step and when the leaf returns
  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      res_value_r <= '0;
      if (!step_ok) begin
        res_status_r <= is_insert ? r256t_pkg::ST_FULL : r256t_pkg::ST_MISS;
      end else begin
        res_status_r <= r256t_pkg::ST_OK;
      end
    end else if (cmd.leaf) begin
      if (node_rdata_r[64]) begin
        res_status_r <= r256t_pkg::ST_OK;
        res_value_r  <= node_rdata_r[63:0];
      end else begin
        res_status_r <= r256t_pkg::ST_MISS;
        res_value_r  <= '0;
      end
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.status     <= res_status_r;
      out_data_r.read_value <= res_value_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clear_last = (clr_cnt_r == CLR_LAST);
  assign sts.step_ok    = step_ok;
  assign sts.is_lookup  = (func_r == r256t_pkg::FUNC_LOOKUP);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

>>> tb/radix256_trie_insert_lookup_checker.sv
`timescale 1ns / 1ps

module radix256_trie_insert_lookup_checker #(
  parameter int NODE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  r256t_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  r256t_pkg::out_item_t out_data,
  output int                   err_count,
  output int                   results_due,
  output int                   stored_cnt,
  output int                   full_cnt,
  output int                   hit_cnt,
  output int                   miss_cnt
);

  // Shadow trie: child index per (node, key byte) slot, zero means no child
  int unsigned child_of   [NODE_COUNT*r256t_pkg::FANOUT];
  logic [63:0] leaf_value [NODE_COUNT];
  bit          is_leaf    [NODE_COUNT];
  int unsigned free_node;
  r256t_pkg::out_item_t pending_results[$];

  // Walk the shadow trie for one operation, allocate on insert, return the result
  function automatic r256t_pkg::out_item_t walk_trie(input r256t_pkg::in_item_t op);
    r256t_pkg::out_item_t res;
    int unsigned node;
    int unsigned slot;
    logic [7:0]  kbyte;
    res.status     = r256t_pkg::ST_OK;
    res.read_value = '0;
    node           = 0;
    for (int lvl = 0; lvl < r256t_pkg::KEY_LEVELS; lvl++) begin
      kbyte = op.key[8*(r256t_pkg::KEY_LEVELS-1-lvl) +: 8];
      slot  = node * r256t_pkg::FANOUT + kbyte;
      if (child_of[slot] == 0) begin
        if (op.func == r256t_pkg::FUNC_LOOKUP) begin
          res.status = r256t_pkg::ST_MISS;
          return res;
        end
        // Pool exhausted: links made so far stay, no leaf is written
        if (free_node >= NODE_COUNT) begin
          res.status = r256t_pkg::ST_FULL;
          return res;
        end
        child_of[slot] = free_node;
        free_node++;
      end
      node = child_of[slot];
    end
    if (op.func == r256t_pkg::FUNC_INSERT) begin
      leaf_value[node] = op.value;
      is_leaf[node]    = 1'b1;
    end else if (is_leaf[node]) begin
      res.read_value = leaf_value[node];
    end else begin
      // Path exists but was left behind by a refused insert
      res.status = r256t_pkg::ST_MISS;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    r256t_pkg::out_item_t want;
    if (!rst_n) begin
      foreach (child_of[i]) child_of[i] = 0;
      foreach (is_leaf[i]) is_leaf[i] = 1'b0;
      foreach (leaf_value[i]) leaf_value[i] = '0;
      free_node = 1;
      pending_results.delete();
      err_count  = 0;
      stored_cnt = 0;
      full_cnt   = 0;
      hit_cnt    = 0;
      miss_cnt   = 0;
    end else begin
      // Retire the oldest expected result against each output transfer
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing outstanding: status %0d, read_value %h",
                 out_data.status, out_data.read_value);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   want.read_value, out_data.read_value);
            err_count++;
          end
        end
      end
      // Predict the result of each input transfer
      if (in_valid && in_ready) begin
        want = walk_trie(in_data);
        pending_results.push_back(want);
        if (in_data.func == r256t_pkg::FUNC_INSERT) begin
          if (want.status == r256t_pkg::ST_OK) stored_cnt++;
          else full_cnt++;
        end else begin
          if (want.status == r256t_pkg::ST_OK) hit_cnt++;
          else miss_cnt++;
        end
      end
    end
    results_due <= pending_results.size();
  end

endmodule

>>> tb/tb_radix256_trie_insert_lookup.sv
`timescale 1ns / 1ps

module tb_radix256_trie_insert_lookup;

  localparam int NODE_COUNT   = 256;
  localparam int RANDOM_OPS   = 800;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  // Covers the table sweep after reset and every operation, with a wide margin
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  r256t_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  r256t_pkg::out_item_t out_data;

  int err_count;
  int results_due;
  int stored_cnt;
  int full_cnt;
  int hit_cnt;
  int miss_cnt;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int cycles       = 0;

  // Keys offered for insert, apart from fully random ones, reused for lookups and derived keys
  logic [63:0] key_bank[$];

  radix256_trie_insert_lookup #(
    .NODE_COUNT(NODE_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  radix256_trie_insert_lookup_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .err_count  (err_count),
    .results_due(results_due),
    .stored_cnt (stored_cnt),
    .full_cnt   (full_cnt),
    .hit_cnt    (hit_cnt),
    .miss_cnt   (miss_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_radix256_trie_insert_lookup: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic r256t_pkg::in_item_t mk_op(logic f, logic [63:0] k, logic [63:0] v);
    r256t_pkg::in_item_t op;
    op.func  = f;
    op.key   = k;
    op.value = v;
    return op;
  endfunction

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // New key sharing a prefix with a known key (sometimes fully random); often only the last level is redrawn
  function automatic logic [63:0] derive_key();
    logic [63:0] k;
    int          from;
    if (key_bank.size() == 0 || $urandom_range(7) == 0) return {$urandom, $urandom};
    k    = key_bank[$urandom_range(key_bank.size() - 1)];
    from = $urandom_range(1) ? r256t_pkg::KEY_LEVELS - 1 :
           $urandom_range(r256t_pkg::KEY_LEVELS - 1);
    for (int lvl = from; lvl < r256t_pkg::KEY_LEVELS; lvl++) begin
      k[8*(r256t_pkg::KEY_LEVELS-1-lvl) +: 8] = 8'($urandom_range(255));
    end
    return k;
  endfunction

  // Offer one operation after a random gap; return at its transfer edge
  task automatic offer_op(input r256t_pkg::in_item_t op);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: empty trie, all-zero and all-ones keys and values,
    // overwrite, misses at the first and last level, shared prefixes
    idle_pct  = 38;
    stall_pct = 38;
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, 64'h0, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0, '1));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, '1, '1));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, '1, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, '1, 64'h5555_5555_5555_5555));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, '1, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, 64'h0000_0000_0000_0100, 64'hAAAA_AAAA_AAAA_AAAA));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0100, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0123_4567_89AB_CDEF, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h0123_4567_89AB_CDEE, 64'h0));
    offer_op(mk_op(r256t_pkg::FUNC_INSERT, 64'h8000_0000_0000_0001, 64'h1));
    offer_op(mk_op(r256t_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0001, 64'h0));
    key_bank.push_back(64'h0);
    key_bank.push_back('1);
    key_bank.push_back(64'h0000_0000_0000_0100);
    key_bank.push_back(64'h0123_4567_89AB_CDEF);
    key_bank.push_back(64'h8000_0000_0000_0001);

    // Random operations in four idling mixes; the pool runs dry early on,
    // so refused inserts and half-built paths get exercised as well
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          holds_asked++;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      for (int n = 0; n < RANDOM_OPS / 4; n++) begin : rand_item
        logic [63:0] k;
        r256t_pkg::in_item_t op;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
          k = derive_key();
          key_bank.push_back(k);
          op = mk_op(r256t_pkg::FUNC_INSERT, k, rand_word());
        end else if (pick < 40) begin
          k  = key_bank[$urandom_range(key_bank.size() - 1)];
          op = mk_op(r256t_pkg::FUNC_INSERT, k, rand_word());
        end else if (pick < 75) begin
          k  = key_bank[$urandom_range(key_bank.size() - 1)];
          op = mk_op(r256t_pkg::FUNC_LOOKUP, k, rand_word());
        end else if (pick < 90) begin
          op = mk_op(r256t_pkg::FUNC_LOOKUP, derive_key(), rand_word());
        end else begin
          op = mk_op(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
        end
        offer_op(op);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for stray transfers
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d inserts stored, %0d refused with the node pool exhausted,",
             stored_cnt, full_cnt);
    $display("Summary: %0d lookup hits, %0d lookup misses", hit_cnt, miss_cnt);
    $display("Summary: directed corner keys, %0d random operations over four mixes,",
             RANDOM_OPS);
    $display("Summary: one %0d-cycle output hold-off", HOLD_CYCLES);
    if (err_count == 0 && results_due == 0) begin
      $display("tb_radix256_trie_insert_lookup: done, clean");
    end else begin
      $display("tb_radix256_trie_insert_lookup: done, errors");
    end
    $finish;
  end

endmodule
